@@ hdl/sbpm_pkg.sv @@
// shared types, constants and helper functions of the ssb burst position mapper
// no dependencies; every other file of the block imports this package
package sbpm_pkg;

  // field widths
  localparam int SlotW    = 20;
  localparam int IdxW     = 6;
  localparam int SymW     = 4;
  localparam int ArfcnW   = 22;
  localparam int PeriodW  = 8;
  localparam int NumerW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int BitmapW  = 64;

  // period in slots is period_ms shifted by up to three, so the remainder fits here
  localparam int RemW = PeriodW + (1 << NumerW) - 1;

  // remainder pipeline: slot bits are consumed msb first, a fixed share per stage
  localparam int NumStages     = 5;
  localparam int StepsPerStage = SlotW / NumStages;

  // slot geometry
  localparam int SymsPerSlot     = 14;
  localparam int SsbSyms         = 4;
  localparam int CaseDBurstSlots = 40;

  // start symbols of the two candidates in a slot
  localparam logic [SymW-1:0] SymTwo   = SymW'(2);
  localparam logic [SymW-1:0] SymFour  = SymW'(4);
  localparam logic [SymW-1:0] SymSix   = SymW'(6);
  localparam logic [SymW-1:0] SymEight = SymW'(8);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_CASE    = 3'd0,
    REG_CARRIER_ARFCN   = 3'd1,
    REG_FDD_MODE        = 3'd2,
    REG_CUTOFF_MAIN     = 3'd3,
    REG_CUTOFF_UNPAIRED = 3'd4,
    REG_POSITION_BITMAP = 3'd5,
    REG_PERIOD_MS       = 3'd6,
    REG_NUMEROLOGY      = 3'd7
  } cfg_reg_e;

  // ssb pattern cases
  typedef enum logic [1:0] {
    CASE_A = 2'd0,
    CASE_B = 2'd1,
    CASE_C = 2'd2,
    CASE_D = 2'd3
  } pattern_e;

  // register reset values
  localparam logic [ArfcnW-1:0]  CutoffMainReset     = ArfcnW'(600000);
  localparam logic [ArfcnW-1:0]  CutoffUnpairedReset = ArfcnW'(376000);
  localparam logic [PeriodW-1:0] PeriodMsReset       = PeriodW'(20);

  // configuration seen by the decode logic
  typedef struct packed {
    pattern_e          pattern_case;
    logic [ArfcnW-1:0] carrier_arfcn;
    logic              fdd_mode;
    logic [ArfcnW-1:0] cutoff_main_arfcn;
    logic [ArfcnW-1:0] cutoff_unpaired_arfcn;
  } cfg_t;

  // word carried through the remainder stages
  typedef struct packed {
    logic [SlotW-1:0] slot;   // original slot, used when the period is zero
    logic [SlotW-1:0] rest;   // slot bits not yet consumed, msb aligned
    logic [RemW-1:0]  rem;    // partial remainder
  } rem_word_t;

  // candidate pair of one slot
  typedef struct packed {
    logic [IdxW-1:0] first_idx;
    logic [SymW-1:0] start0;
    logic [SymW-1:0] start1;
  } cand_t;

  // one restoring remainder step: shift in a dividend bit, subtract if it fits
  function automatic logic [RemW-1:0] rem_step(logic [RemW-1:0] r, logic b,
                                               logic [RemW-1:0] d);
    logic [RemW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[RemW-1:0];
  endfunction

  // position of a case d slot pair among the pairs that carry ssbs (pair - pair/5)
  function automatic logic [3:0] pair_rank(logic [4:0] pair);
    logic [4:0] grp;
    logic [4:0] r;
    if (pair >= 5'd15) begin
      grp = 5'd3;
    end else if (pair >= 5'd10) begin
      grp = 5'd2;
    end else if (pair >= 5'd5) begin
      grp = 5'd1;
    end else begin
      grp = 5'd0;
    end
    r = pair - grp;
    return r[3:0];
  endfunction

  // exclusive end symbol: start plus ssb length, wrapped at the slot length
  function automatic logic [SymW-1:0] end_sym(logic [SymW-1:0] st);
    logic [SymW:0] t;
    t = {1'b0, st} + (SymW + 1)'(SsbSyms);
    if (t >= (SymW + 1)'(SymsPerSlot)) begin
      t = t - (SymW + 1)'(SymsPerSlot);
    end
    return t[SymW-1:0];
  endfunction

endpackage

@@ hdl/sbpm_rem_stage.sv @@
// one stage of the slot modulo period pipeline: a fixed number of remainder steps
// depends on sbpm_pkg
module sbpm_rem_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sbpm_pkg::rem_word_t           data_i,
  input  logic [sbpm_pkg::RemW-1:0]     divisor_i,
  output logic                          valid_o,
  output sbpm_pkg::rem_word_t           data_o
);
  import sbpm_pkg::*;

  logic      valid_q;
  rem_word_t data_q, data_d;

  // consume the top slot bits, one compare and subtract each
  always_comb begin
    data_d = data_i;
    for (int j = 0; j < StepsPerStage; j++) begin
      data_d.rem  = rem_step(data_d.rem, data_d.rest[SlotW-1], divisor_i);
      data_d.rest = {data_d.rest[SlotW-2:0], 1'b0};
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/sbpm_decode.sv @@
// candidate rule of pattern cases a to d applied to the reduced slot
// depends on sbpm_pkg
module sbpm_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sbpm_pkg::rem_word_t           data_i,
  input  logic [sbpm_pkg::RemW-1:0]     divisor_i,
  input  sbpm_pkg::cfg_t                cfg_i,
  output logic                          valid_o,
  output sbpm_pkg::cand_t               cand_o
);
  import sbpm_pkg::*;

  logic [SlotW-1:0] s;
  logic             s_le1, s_le3, s_lt40, odd, low, ok;
  logic [4:0]       pair;
  logic [ArfcnW-1:0] cutoff;
  cand_t            cand_d, cand_q;
  logic             valid_q;

  // reduced slot; a zero period leaves the slot as it is
  always_comb begin
    if (divisor_i == '0) begin
      s = data_i.slot;
    end else begin
      s = SlotW'(data_i.rem);
    end
    s_le1  = (s[SlotW-1:1] == '0);
    s_le3  = (s[SlotW-1:2] == '0);
    s_lt40 = (s < SlotW'(CaseDBurstSlots));
    odd    = s[0];
    pair   = s[5:1];
  end

  // carrier versus cutoff test
  always_comb begin
    if (cfg_i.pattern_case == CASE_C && !cfg_i.fdd_mode) begin
      cutoff = cfg_i.cutoff_unpaired_arfcn;
    end else begin
      cutoff = cfg_i.cutoff_main_arfcn;
    end
    low = (cfg_i.carrier_arfcn <= cutoff);
  end

  // candidate positions per pattern case
  always_comb begin
    cand_d.first_idx = {3'b000, s[1:0], 1'b0};
    cand_d.start0    = SymTwo;
    cand_d.start1    = SymEight;
    ok               = 1'b0;
    unique case (cfg_i.pattern_case)
      CASE_A, CASE_C: begin
        ok = low ? s_le1 : s_le3;
      end
      CASE_B: begin
        ok            = low ? s_le1 : s_le3;
        cand_d.start0 = odd ? SymTwo : SymFour;
        cand_d.start1 = odd ? SymSix : SymEight;
      end
      CASE_D: begin
        ok = s_lt40 && (pair != 5'd4) && (pair != 5'd9) && (pair != 5'd14)
             && (pair != 5'd19);
        cand_d.first_idx = {pair_rank(pair), odd, 1'b0};
        cand_d.start0    = odd ? SymTwo : SymFour;
        cand_d.start1    = odd ? SymSix : SymEight;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && ok;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign cand_o  = cand_q;

endmodule

@@ hdl/sbpm_emit.sv @@
// bitmap filter and result output; a pair of hits goes out as two words and holds the pipe
// depends on sbpm_pkg
module sbpm_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  sbpm_pkg::cand_t                 cand_i,
  input  logic [sbpm_pkg::BitmapW-1:0]    bitmap_i,
  output logic                            stall_o,
  output logic                            result_valid_o,
  output logic [sbpm_pkg::IdxW-1:0]       beam_idx_o,
  output logic [sbpm_pkg::SymW-1:0]       start_symbol_o,
  output logic [sbpm_pkg::SymW-1:0]       end_symbol_o,
  output logic                            last_o
);
  import sbpm_pkg::*;

  logic [IdxW-1:0] second_idx;
  logic            hit0, hit1;

  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic [SymW-1:0] pend_st_q, pend_st_d;

  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] out_idx_q, out_idx_d;
  logic [SymW-1:0] out_st_q, out_st_d;
  logic            out_last_q, out_last_d;

  // bitmap lookup of both candidates
  always_comb begin
    second_idx = cand_i.first_idx + IdxW'(1);
    hit0       = bitmap_i[cand_i.first_idx];
    hit1       = bitmap_i[second_idx];
  end

  // output selection: a held second word goes first, then the next candidate pair
  always_comb begin
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    pend_st_d   = pend_st_q;
    out_valid_d = 1'b0;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
      out_idx_d   = pend_idx_q;
      out_st_d    = pend_st_q;
      out_last_d  = 1'b1;
    end else if (valid_i) begin
      if (hit0) begin
        out_valid_d = 1'b1;
        out_idx_d   = cand_i.first_idx;
        out_st_d    = cand_i.start0;
        out_last_d  = !hit1;
        pend_d      = hit1;
        pend_idx_d  = second_idx;
        pend_st_d   = cand_i.start1;
      end else if (hit1) begin
        out_valid_d = 1'b1;
        out_idx_d   = second_idx;
        out_st_d    = cand_i.start1;
        out_last_d  = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    pend_st_q  <= pend_st_d;
    out_idx_q  <= out_idx_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
  end

  assign stall_o        = pend_q;
  assign result_valid_o = out_valid_q;
  assign beam_idx_o     = out_idx_q;
  assign start_symbol_o = out_st_q;
  assign end_symbol_o   = end_sym(out_st_q);
  assign last_o         = out_last_q;

endmodule

@@ hdl/ssb_burst_position_mapper_top.sv @@
// ssb burst position mapper: configuration registers, modulo pipeline, decode, output
// depends on sbpm_pkg, sbpm_rem_stage, sbpm_decode, sbpm_emit
//
//   channel   handshake                     payload
//   ------    ---------------------------   ----------------------------------------
//   slot in   start_i, busy_o               slot_index_i
//   result    result_valid_o (strobe)       beam_idx_o, start_symbol_o,
//                                           end_symbol_o, last_o
//   config    cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// a slot word is taken when start_i is high and busy_o low; its results pass through
// the five remainder stages, the decode register and the output register.
// a new slot can enter every cycle while busy_o is low; a slot with two results holds
// the whole pipe while its second word goes out, with busy_o high for a single cycle.
// reset clears all valid bits and loads the register defaults; no clearing pass.
module ssb_burst_position_mapper_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [sbpm_pkg::SlotW-1:0]        slot_index_i,
  input  logic                              cfg_we_i,
  input  logic [sbpm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sbpm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic                              result_valid_o,
  output logic [sbpm_pkg::IdxW-1:0]         beam_idx_o,
  output logic [sbpm_pkg::SymW-1:0]         start_symbol_o,
  output logic [sbpm_pkg::SymW-1:0]         end_symbol_o,
  output logic                              last_o
);
  import sbpm_pkg::*;

  cfg_t               cfg_q;
  logic [BitmapW-1:0] bitmap_q;
  logic [PeriodW-1:0] period_ms_q;
  logic [NumerW-1:0]  numerology_q;
  logic [RemW-1:0]    divisor;

  logic               stall, en;
  logic               stg_valid [NumStages+1];
  rem_word_t          stg_data  [NumStages+1];
  logic               dec_valid;
  cand_t              dec_cand;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_case          <= CASE_A;
      cfg_q.carrier_arfcn         <= '0;
      cfg_q.fdd_mode              <= 1'b1;
      cfg_q.cutoff_main_arfcn     <= CutoffMainReset;
      cfg_q.cutoff_unpaired_arfcn <= CutoffUnpairedReset;
      bitmap_q                    <= '0;
      period_ms_q                 <= PeriodMsReset;
      numerology_q                <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN_CASE:    cfg_q.pattern_case          <= pattern_e'(cfg_wdata_i[1:0]);
        REG_CARRIER_ARFCN:   cfg_q.carrier_arfcn         <= cfg_wdata_i[ArfcnW-1:0];
        REG_FDD_MODE:        cfg_q.fdd_mode              <= cfg_wdata_i[0];
        REG_CUTOFF_MAIN:     cfg_q.cutoff_main_arfcn     <= cfg_wdata_i[ArfcnW-1:0];
        REG_CUTOFF_UNPAIRED: cfg_q.cutoff_unpaired_arfcn <= cfg_wdata_i[ArfcnW-1:0];
        REG_POSITION_BITMAP: bitmap_q                    <= cfg_wdata_i[BitmapW-1:0];
        REG_PERIOD_MS:       period_ms_q                 <= cfg_wdata_i[PeriodW-1:0];
        REG_NUMEROLOGY:      numerology_q                <= cfg_wdata_i[NumerW-1:0];
        default: begin
        end
      endcase
    end
  end

  // period in slots
  assign divisor = RemW'(period_ms_q) << numerology_q;

  // pipeline advance: the output stage holds everything while a second word is out
  assign en     = !stall;
  assign busy_o = stall;

  // remainder pipeline input
  assign stg_valid[0]     = start_i;
  assign stg_data[0].slot = slot_index_i;
  assign stg_data[0].rest = slot_index_i;
  assign stg_data[0].rem  = '0;

  for (genvar g = 0; g < NumStages; g++) begin : g_rem
    sbpm_rem_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (stg_valid[g]),
      .data_i    (stg_data[g]),
      .divisor_i (divisor),
      .valid_o   (stg_valid[g+1]),
      .data_o    (stg_data[g+1])
    );
  end

  // candidate decode
  sbpm_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (stg_valid[NumStages]),
    .data_i    (stg_data[NumStages]),
    .divisor_i (divisor),
    .cfg_i     (cfg_q),
    .valid_o   (dec_valid),
    .cand_o    (dec_cand)
  );

  // bitmap filter and output words
  sbpm_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (dec_valid),
    .cand_i         (dec_cand),
    .bitmap_i       (bitmap_q),
    .stall_o        (stall),
    .result_valid_o (result_valid_o),
    .beam_idx_o     (beam_idx_o),
    .start_symbol_o (start_symbol_o),
    .end_symbol_o   (end_symbol_o),
    .last_o         (last_o)
  );

endmodule

@@ bench/ssb_burst_position_mapper_checker.sv @@
// checker for the ssb burst position mapper: watches slot, config and result channels,
// predicts the ssb words of every accepted slot and compares them in order
// depends on sbpm_pkg
module ssb_burst_position_mapper_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [sbpm_pkg::SlotW-1:0]    slot_index_i,
  input  logic                          cfg_we_i,
  input  logic [sbpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sbpm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          result_valid_i,
  input  logic [sbpm_pkg::IdxW-1:0]     beam_idx_i,
  input  logic [sbpm_pkg::SymW-1:0]     start_symbol_i,
  input  logic [sbpm_pkg::SymW-1:0]     end_symbol_i,
  input  logic                          last_i,
  output int                            error_count_o,
  output int                            pending_o
);
  import sbpm_pkg::*;

  // one expected result word
  typedef struct packed {
    logic [IdxW-1:0] beam_idx;
    logic [SymW-1:0] start_sym;
    logic [SymW-1:0] stop_sym;
    logic            last;
  } ssb_word_t;

  // shadow copy of the configuration registers
  pattern_e           case_sel;
  logic [ArfcnW-1:0]  carrier;
  logic               paired;
  logic [ArfcnW-1:0]  cut_main;
  logic [ArfcnW-1:0]  cut_unpaired;
  logic [BitmapW-1:0] bitmap;
  logic [PeriodW-1:0] period;
  logic [NumerW-1:0]  numer;

  ssb_word_t expected_words[$];
  ssb_word_t want_word;
  int        errors = 0;
  int        pending = 0;

  assign error_count_o = errors;
  assign pending_o     = pending;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // queue one candidate if its bitmap bit is set; returns the number queued
  function automatic int add_candidate(input int unsigned idx, input int unsigned start);
    ssb_word_t w;
    if (!bitmap[idx & 63]) begin
      return 0;
    end
    w.beam_idx  = IdxW'(idx & 63);
    w.start_sym = SymW'(start % SymsPerSlot);
    w.stop_sym  = SymW'((start + SsbSyms) % SymsPerSlot);
    w.last      = 1'b0;
    expected_words.insert(expected_words.size(), w);
    return 1;
  endfunction

  // candidate positions of one slot under the current configuration
  function automatic void map_slot(input logic [SlotW-1:0] slot);
    int unsigned period_slots;
    int unsigned s;
    int unsigned cutoff;
    int unsigned max_slot;
    int unsigned pair;
    int unsigned first;
    bit          odd;
    int          n;
    ssb_word_t   tail;
    period_slots = 32'(period) << numer;
    s = (period_slots != 0) ? 32'(slot) % period_slots : 32'(slot);
    odd = s[0];
    n = 0;
    case (case_sel)
      CASE_A, CASE_C: begin
        cutoff = (case_sel == CASE_C && !paired) ? 32'(cut_unpaired) : 32'(cut_main);
        max_slot = (32'(carrier) <= cutoff) ? 1 : 3;
        if (s <= max_slot) begin
          n += add_candidate(2 * s, 2);
          n += add_candidate(2 * s + 1, 8);
        end
      end
      CASE_B: begin
        max_slot = (carrier <= cut_main) ? 1 : 3;
        if (s <= max_slot) begin
          n += add_candidate(2 * s, odd ? 2 : 4);
          n += add_candidate(2 * s + 1, odd ? 6 : 8);
        end
      end
      default: begin
        // case d: every fifth slot pair carries nothing
        pair = s / 2;
        if (s < CaseDBurstSlots && pair % 5 != 4) begin
          first = 4 * (pair - pair / 5) + (odd ? 2 : 0);
          n += add_candidate(first, odd ? 2 : 4);
          n += add_candidate(first + 1, odd ? 6 : 8);
        end
      end
    endcase
    if (n > 0) begin
      tail = expected_words.pop_back();
      tail.last = 1'b1;
      expected_words.insert(expected_words.size(), tail);
    end
  endfunction

  // compare results, follow config writes, predict accepted slots
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_sel     = CASE_A;
      carrier      = '0;
      paired       = 1'b1;
      cut_main     = CutoffMainReset;
      cut_unpaired = CutoffUnpairedReset;
      bitmap       = '0;
      period       = PeriodMsReset;
      numer        = '0;
      expected_words.delete();
      pending      = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word with no expectation: ssb %0d start %0d",
                                    beam_idx_i, start_symbol_i));
        end else begin
          want_word = expected_words.pop_front();
          if (beam_idx_i !== want_word.beam_idx)
            report_mismatch($sformatf("beam_idx got %0d want %0d",
                                      beam_idx_i, want_word.beam_idx));
          if (start_symbol_i !== want_word.start_sym)
            report_mismatch($sformatf("start_symbol got %0d want %0d (ssb %0d)",
                                      start_symbol_i, want_word.start_sym,
                                      want_word.beam_idx));
          if (end_symbol_i !== want_word.stop_sym)
            report_mismatch($sformatf("end_symbol got %0d want %0d (ssb %0d)",
                                      end_symbol_i, want_word.stop_sym,
                                      want_word.beam_idx));
          if (last_i !== want_word.last)
            report_mismatch($sformatf("last got %0b want %0b (ssb %0d)",
                                      last_i, want_word.last, want_word.beam_idx));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_CASE:    case_sel     = pattern_e'(cfg_wdata_i[1:0]);
          REG_CARRIER_ARFCN:   carrier      = cfg_wdata_i[ArfcnW-1:0];
          REG_FDD_MODE:        paired       = cfg_wdata_i[0];
          REG_CUTOFF_MAIN:     cut_main     = cfg_wdata_i[ArfcnW-1:0];
          REG_CUTOFF_UNPAIRED: cut_unpaired = cfg_wdata_i[ArfcnW-1:0];
          REG_POSITION_BITMAP: bitmap       = cfg_wdata_i[BitmapW-1:0];
          REG_PERIOD_MS:       period       = cfg_wdata_i[PeriodW-1:0];
          default:             numer        = cfg_wdata_i[NumerW-1:0];
        endcase
      end
      if (start_i && !busy_i) begin
        map_slot(slot_index_i);
      end
      pending = expected_words.size();
    end
  end

endmodule

@@ bench/ssb_burst_position_mapper_top_test.sv @@
// top of the ssb burst position mapper bench: clock, reset, config phases and slot stimulus
// depends on sbpm_pkg, ssb_burst_position_mapper_top, ssb_burst_position_mapper_checker
module ssb_burst_position_mapper_top_test;
  import sbpm_pkg::*;

  localparam int ResetCycles = 9;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 200000;
  localparam int MaxArfcn    = 3279165;
  localparam int RandPhases  = 11;
  localparam int PhaseWords  = 50;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [SlotW-1:0]    slot_index;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                result_valid;
  logic [IdxW-1:0]     beam_idx;
  logic [SymW-1:0]     start_symbol;
  logic [SymW-1:0]     end_symbol;
  logic                last;

  int          error_count;
  int          pending_words;
  int          cycles = 0;
  int unsigned period_slots;

  always #2 clk = ~clk;

  ssb_burst_position_mapper_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .slot_index_i   (slot_index),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .beam_idx_o     (beam_idx),
    .start_symbol_o (start_symbol),
    .end_symbol_o   (end_symbol),
    .last_o         (last)
  );

  ssb_burst_position_mapper_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .slot_index_i   (slot_index),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_i (result_valid),
    .beam_idx_i     (beam_idx),
    .start_symbol_i (start_symbol),
    .end_symbol_i   (end_symbol),
    .last_i         (last),
    .error_count_o  (error_count),
    .pending_o      (pending_words)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d words outstanding", cycles, pending_words);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  // stop sending, let every expected word arrive plus the pipe drain, then load all registers
  task automatic apply_config(input pattern_e pc, input int unsigned carrier,
                              input bit paired, input int unsigned cut_main,
                              input int unsigned cut_unpaired, input logic [63:0] bitmap,
                              input int unsigned period, input int unsigned numer);
    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    write_reg(REG_PATTERN_CASE, 64'(pc));
    write_reg(REG_CARRIER_ARFCN, 64'(carrier));
    write_reg(REG_FDD_MODE, 64'(paired));
    write_reg(REG_CUTOFF_MAIN, 64'(cut_main));
    write_reg(REG_CUTOFF_UNPAIRED, 64'(cut_unpaired));
    write_reg(REG_POSITION_BITMAP, bitmap);
    write_reg(REG_PERIOD_MS, 64'(period & 8'hFF));
    write_reg(REG_NUMEROLOGY, 64'(numer & 2'h3));
    @(negedge clk);
    cfg_we <= 1'b0;
    period_slots = (period & 8'hFF) << (numer & 2'h3);
  endtask

  // present one slot word and hold it until taken
  task automatic send_slot(input logic [SlotW-1:0] slot);
    @(negedge clk);
    start      <= 1'b1;
    slot_index <= slot;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start      <= 1'b0;
      slot_index <= SlotW'($urandom);
    end
  endtask

  // mostly slots landing near the start of a period, the rest anywhere in 20 bits
  function automatic logic [SlotW-1:0] pick_slot();
    int unsigned s;
    int unsigned base;
    s = $urandom_range(0, 41);
    if ($urandom_range(0, 9) >= 6) begin
      return SlotW'($urandom);
    end
    if (period_slots == 0) begin
      return SlotW'(s);
    end
    base = $urandom_range(0, 20'hFFFFF / period_slots) * period_slots;
    return SlotW'(base + s);
  endfunction

  task automatic random_config(input int phase);
    pattern_e    pc;
    int unsigned cut_main;
    int unsigned cut_unpaired;
    int unsigned carrier;
    int unsigned period;
    int unsigned pick;
    logic [63:0] bitmap;
    int unsigned periods[6] = '{5, 10, 20, 40, 80, 160};
    pc = pattern_e'($urandom_range(0, 3));
    cut_main = $urandom_range(0, MaxArfcn);
    cut_unpaired = $urandom_range(0, MaxArfcn);
    pick = $urandom_range(0, 3);
    carrier = (pick == 0) ? cut_main :
              (pick == 1) ? cut_unpaired :
              (pick == 2) ? ((cut_main < MaxArfcn) ? cut_main + 1 : cut_main) :
              $urandom_range(0, MaxArfcn);
    pick = $urandom_range(0, 7);
    bitmap = (pick <= 2) ? '1 :
             (pick <= 5) ? {$urandom, $urandom} :
             (pick == 6) ? (64'd1 << $urandom_range(0, 63)) : '0;
    pick = $urandom_range(0, 9);
    period = (pick < 7) ? periods[$urandom_range(0, 5)] :
             (pick == 7) ? 0 :
             (pick == 8) ? 255 : $urandom_range(1, 255);
    // extremes of the ranges on the first two phases
    if (phase == 0) begin
      apply_config(pc, 0, $urandom_range(0, 1), MaxArfcn, MaxArfcn, '1, 5, 0);
    end else if (phase == 1) begin
      apply_config(pc, MaxArfcn, $urandom_range(0, 1), 0, 0, '1, 160, 3);
    end else begin
      apply_config(pc, carrier, $urandom_range(0, 1), cut_main, cut_unpaired, bitmap,
                   period, $urandom_range(0, 3));
    end
  endtask

  // bursts of slots with random gaps, or one gapless stretch
  task automatic random_slots(input int count);
    int  sent;
    int  burst;
    bit  gapless;
    gapless = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          send_slot(pick_slot());
          sent++;
        end
      end
      if (!gapless) idle_for($urandom_range(0, 6));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    slot_index = '0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_PATTERN_CASE;
    cfg_wdata  = '0;
    period_slots = 20;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // case a, carrier at or below cutoff: only slots 0 and 1 of the period
    apply_config(CASE_A, 0, 1'b1, 600000, 376000, '1, 20, 0);
    send_slot(0);
    send_slot(1);
    send_slot(2);
    send_slot(3);
    send_slot(20'hFFFFF);
    send_slot(21);

    // case b above cutoff, zero period: slot used without reduction
    apply_config(CASE_B, 600001, 1'b1, 600000, 376000, '1, 0, 3);
    send_slot(0);
    send_slot(1);
    send_slot(2);
    send_slot(3);
    send_slot(4);

    // case c unpaired, carrier equal to the unpaired cutoff, odd indices only
    apply_config(CASE_C, 376000, 1'b0, 0, 376000, 64'hAAAA_AAAA_AAAA_AAAA, 10, 0);
    send_slot(0);
    send_slot(1);
    send_slot(2);

    // case d with an unusual period, including the empty pairs and the top indices
    apply_config(CASE_D, 0, 1'b1, 600000, 376000, '1, 255, 1);
    send_slot(0);
    send_slot(1);
    send_slot(8);
    send_slot(9);
    idle_for(3);
    send_slot(36);
    send_slot(37);
    send_slot(38);
    send_slot(39);
    send_slot(40);
    send_slot(510);

    for (int p = 0; p < RandPhases; p++) begin
      random_config(p);
      random_slots(PhaseWords);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ ssb_burst_position_mapper_top.f @@
hdl/sbpm_pkg.sv
hdl/sbpm_rem_stage.sv
hdl/sbpm_decode.sv
hdl/sbpm_emit.sv
hdl/ssb_burst_position_mapper_top.sv
bench/ssb_burst_position_mapper_checker.sv
bench/ssb_burst_position_mapper_top_test.sv
